[src/polar_ring_sector_classifier_macros.svh]
// Assertion macros shared by the checker of the polar ring/sector classifier
`ifndef POLAR_RING_SECTOR_CLASSIFIER_MACROS_SVH
`define POLAR_RING_SECTOR_CLASSIFIER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PRC_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define PRC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/prc_pkg.sv]
// Types and constants of the polar ring/sector classifier
package prc_pkg;

  // Field widths
  localparam int unsigned POS_W   = 9;   // cell column / row
  localparam int unsigned HALF_W  = 8;   // window half width
  localparam int unsigned OFS_W   = POS_W + 1;  // signed offset
  localparam int unsigned ABS_W   = POS_W;      // |offset|
  localparam int unsigned SQ_W    = 2 * ABS_W;  // offset squared
  localparam int unsigned SUM_W   = ABS_W + 1;  // |x| + |y|
  localparam int unsigned SSQ_W   = 2 * SUM_W;  // (|x| + |y|) squared
  localparam int unsigned D2_W    = SQ_W + 1;   // x^2 + y^2
  localparam int unsigned RAD_W   = 17;  // squared ring radius
  localparam int unsigned RCNT_W  = 3;   // ring count register
  localparam int unsigned RING_W  = 3;   // ring index
  localparam int unsigned SEC_W   = 3;   // sector
  localparam int unsigned SEG_W   = 6;   // segment id
  localparam int unsigned SECTORS = 8;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = RAD_W;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_SIZE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RING_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RING1_RAD  = 3'd2;

  // Reset values of the configuration registers
  localparam logic [HALF_W-1:0] HALF_SIZE_RST  = 8'd5;
  localparam logic [RCNT_W-1:0] RING_COUNT_RST = 3'd1;
  localparam logic [RAD_W-1:0]  RING_RAD_RST   = 17'd25;

  // Sector codes, y grows downward
  localparam logic [SEC_W-1:0] SEC_NW = 3'd0;
  localparam logic [SEC_W-1:0] SEC_N  = 3'd1;
  localparam logic [SEC_W-1:0] SEC_NE = 3'd2;
  localparam logic [SEC_W-1:0] SEC_E  = 3'd3;
  localparam logic [SEC_W-1:0] SEC_SE = 3'd4;
  localparam logic [SEC_W-1:0] SEC_S  = 3'd5;
  localparam logic [SEC_W-1:0] SEC_SW = 3'd6;
  localparam logic [SEC_W-1:0] SEC_W_ = 3'd7;

  // Squares stage to classify stage
  typedef struct packed {
    logic [SQ_W-1:0]  ax_sq;
    logic [SQ_W-1:0]  ay_sq;
    logic [SSQ_W-1:0] s_sq;
    logic             x_pos;
    logic             y_pos;
    logic             centre;
  } sq_t;

  // One classified cell
  typedef struct packed {
    logic [SEG_W-1:0]  segment_id;
    logic [RING_W-1:0] ring_index;
    logic [SEC_W-1:0]  sector;
    logic              outside;
  } res_t;

endpackage

[src/polar_ring_sector_classifier.sv]
// Top level of the polar ring/sector classifier
//
//   Channel  Direction  Handshake                 Payload
//   in       request in in_valid_i / in_ready_o   cell_col_i, cell_row_i
//   out      result out out_valid_o / out_ready_i segment_id_o, ring_index_o,
//                                                 sector_o, outside_o
//   cfg      write in   cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// One request per clock sustained while out_ready_i is high; out_valid_o follows
// the accepting edge through the input register, square register and result register.
// The 9x9-bit and 10x10-bit squares and the radius compares set the stage depth.
// Each stage holds its request while the one after it is full and stalled,
// so a waiting result does not block new requests until all three are full.
// Reset clears all valid flags and loads the register defaults; no clear pass.
module polar_ring_sector_classifier #(
  parameter int unsigned MAX_RINGS = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Cell requests
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [prc_pkg::POS_W-1:0]       cell_col_i,
  input  logic [prc_pkg::POS_W-1:0]       cell_row_i,
  // Classified cells
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [prc_pkg::SEG_W-1:0]       segment_id_o,
  output logic [prc_pkg::RING_W-1:0]      ring_index_o,
  output logic [prc_pkg::SEC_W-1:0]       sector_o,
  output logic                            outside_o,
  // Register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [prc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import prc_pkg::*;

  logic              in_valid_q;
  logic [POS_W-1:0]  col_q;
  logic [POS_W-1:0]  row_q;
  logic              sq_ready;
  logic              sq_valid;
  sq_t               sq;
  logic              cls_ready;
  res_t              res;
  logic [HALF_W-1:0] half_size;
  logic [RCNT_W-1:0] ring_count;
  logic [RAD_W-1:0]  ring_rad [MAX_RINGS];

  // Registers are always writable
  assign cfg_ready_o = 1'b1;

  prc_cfg_regs #(
    .MAX_RINGS (MAX_RINGS)
  ) u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .we_i         (cfg_valid_i && cfg_ready_o),
    .index_i      (cfg_index_i),
    .data_i       (cfg_data_i),
    .half_size_o  (half_size),
    .ring_count_o (ring_count),
    .ring_rad_o   (ring_rad)
  );

  // Input register
  assign in_ready_o = !in_valid_q || sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      col_q <= cell_col_i;
      row_q <= cell_row_i;
    end
  end

  prc_sq_stage u_sq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_q),
    .ready_o     (sq_ready),
    .col_i       (col_q),
    .row_i       (row_q),
    .half_size_i (half_size),
    .valid_o     (sq_valid),
    .ready_i     (cls_ready),
    .sq_o        (sq)
  );

  prc_cls_stage #(
    .MAX_RINGS (MAX_RINGS)
  ) u_cls (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (sq_valid),
    .ready_o      (cls_ready),
    .sq_i         (sq),
    .ring_count_i (ring_count),
    .ring_rad_i   (ring_rad),
    .valid_o      (out_valid_o),
    .ready_i      (out_ready_i),
    .res_o        (res)
  );

  assign segment_id_o = res.segment_id;
  assign ring_index_o = res.ring_index;
  assign sector_o     = res.sector;
  assign outside_o    = res.outside;

endmodule

[src/prc_cfg_regs.sv]
// Configuration register file: half size, ring count and ring radii
module prc_cfg_regs #(
  parameter int unsigned MAX_RINGS = 6
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             we_i,
  input  logic [prc_pkg::CFG_IDX_W-1:0]    index_i,
  input  logic [prc_pkg::CFG_DATA_W-1:0]   data_i,
  output logic [prc_pkg::HALF_W-1:0]       half_size_o,
  output logic [prc_pkg::RCNT_W-1:0]       ring_count_o,
  output logic [prc_pkg::RAD_W-1:0]        ring_rad_o [MAX_RINGS]
);
  import prc_pkg::*;

  logic [HALF_W-1:0] half_size_q;
  logic [RCNT_W-1:0] ring_count_q;
  logic [RAD_W-1:0]  ring_rad_q [MAX_RINGS];

  // Register writes; indexes past the last stored ring are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_size_q  <= HALF_SIZE_RST;
      ring_count_q <= RING_COUNT_RST;
      for (int r = 0; r < MAX_RINGS; r++) begin
        ring_rad_q[r] <= RING_RAD_RST;
      end
    end else if (we_i) begin
      if (index_i == CFG_HALF_SIZE) begin
        half_size_q <= data_i[HALF_W-1:0];
      end
      if (index_i == CFG_RING_COUNT) begin
        ring_count_q <= data_i[RCNT_W-1:0];
      end
      for (int r = 0; r < MAX_RINGS; r++) begin
        if (index_i == CFG_IDX_W'(CFG_RING1_RAD + r)) begin
          ring_rad_q[r] <= data_i[RAD_W-1:0];
        end
      end
    end
  end

  assign half_size_o  = half_size_q;
  assign ring_count_o = ring_count_q;
  assign ring_rad_o   = ring_rad_q;

endmodule

[src/prc_sq_stage.sv]
// Offset, magnitude and square stage
module prc_sq_stage (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [prc_pkg::POS_W-1:0]   col_i,
  input  logic [prc_pkg::POS_W-1:0]   row_i,
  input  logic [prc_pkg::HALF_W-1:0]  half_size_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output prc_pkg::sq_t                sq_o
);
  import prc_pkg::*;

  logic             valid_q;
  sq_t              sq_q;
  sq_t              sq_d;
  logic [OFS_W-1:0] x_ofs;
  logic [OFS_W-1:0] y_ofs;
  logic [OFS_W-1:0] x_mag;
  logic [OFS_W-1:0] y_mag;
  logic [ABS_W-1:0] ax;
  logic [ABS_W-1:0] ay;
  logic [SUM_W-1:0] s;

  assign ready_o = !valid_q || ready_i;

  // Signed offsets from the window centre, their magnitudes and squares
  always_comb begin
    x_ofs = {1'b0, col_i} - {2'b00, half_size_i};
    y_ofs = {1'b0, row_i} - {2'b00, half_size_i};
    x_mag = x_ofs[OFS_W-1] ? (~x_ofs + 1'b1) : x_ofs;
    y_mag = y_ofs[OFS_W-1] ? (~y_ofs + 1'b1) : y_ofs;
    ax    = x_mag[ABS_W-1:0];
    ay    = y_mag[ABS_W-1:0];
    s     = {1'b0, ax} + {1'b0, ay};
    sq_d.ax_sq  = SQ_W'(ax) * SQ_W'(ax);
    sq_d.ay_sq  = SQ_W'(ay) * SQ_W'(ay);
    sq_d.s_sq   = SSQ_W'(s) * SSQ_W'(s);
    sq_d.x_pos  = !x_ofs[OFS_W-1] && (x_ofs != '0);
    sq_d.y_pos  = !y_ofs[OFS_W-1] && (y_ofs != '0);
    sq_d.centre = (x_ofs == '0) && (y_ofs == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      sq_q <= sq_d;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;

endmodule

[src/prc_cls_stage.sv]
// Ring search, sector decision and result register
module prc_cls_stage #(
  parameter int unsigned MAX_RINGS = 6
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  prc_pkg::sq_t                sq_i,
  input  logic [prc_pkg::RCNT_W-1:0]  ring_count_i,
  input  logic [prc_pkg::RAD_W-1:0]   ring_rad_i [MAX_RINGS],
  output logic                        valid_o,
  input  logic                        ready_i,
  output prc_pkg::res_t               res_o
);
  import prc_pkg::*;

  localparam logic [RCNT_W-1:0] MaxRingsC = RCNT_W'(MAX_RINGS);

  logic              valid_q;
  res_t              res_q;
  res_t              res_d;
  logic [D2_W-1:0]   d2;
  logic [SSQ_W-1:0]  two_ax_sq;
  logic [SSQ_W-1:0]  two_ay_sq;
  logic [RCNT_W-1:0] rings_used;
  logic              found;
  logic [RING_W-1:0] ring;
  logic [SEC_W-1:0]  sec;

  assign ready_o = !valid_q || ready_i;

  // Innermost ring in use whose bound covers the squared distance
  always_comb begin
    d2         = {1'b0, sq_i.ax_sq} + {1'b0, sq_i.ay_sq};
    rings_used = (ring_count_i > MaxRingsC) ? MaxRingsC : ring_count_i;
    found      = 1'b0;
    ring       = '0;
    for (int r = MAX_RINGS - 1; r >= 0; r--) begin
      if ((RCNT_W'(r) < rings_used) && (d2 <= D2_W'(ring_rad_i[r]))) begin
        found = 1'b1;
        ring  = RING_W'(r);
      end
    end
  end

  // Octant edges at tan(22.5 deg): compare (|x|+|y|)^2 with 2x^2 and 2y^2
  always_comb begin
    two_ax_sq = {1'b0, sq_i.ax_sq, 1'b0};
    two_ay_sq = {1'b0, sq_i.ay_sq, 1'b0};
    if (sq_i.s_sq < two_ax_sq) begin
      sec = sq_i.x_pos ? SEC_E : SEC_W_;
    end else if (sq_i.s_sq < two_ay_sq) begin
      sec = sq_i.y_pos ? SEC_S : SEC_N;
    end else if (sq_i.x_pos) begin
      sec = sq_i.y_pos ? SEC_SE : SEC_NE;
    end else begin
      sec = sq_i.y_pos ? SEC_SW : SEC_NW;
    end
  end

  // Result: centre and outside cells carry zero ring, sector and segment
  always_comb begin
    res_d = '0;
    if (!sq_i.centre) begin
      if (found) begin
        res_d.ring_index = ring;
        res_d.sector     = sec;
        res_d.segment_id = {ring, sec} + SEG_W'(1);
      end else begin
        res_d.outside = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

[src/prc_checker.sv]
// Port-level checks of the polar ring/sector classifier, bound to the top level
`include "polar_ring_sector_classifier_macros.svh"

module prc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [prc_pkg::SEG_W-1:0]   segment_id_o,
  input logic [prc_pkg::RING_W-1:0]  ring_index_o,
  input logic [prc_pkg::SEC_W-1:0]   sector_o,
  input logic                        outside_o
);
  import prc_pkg::*;

  // A stalled result keeps its value
  `PRC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(segment_id_o) && $stable(ring_index_o) && $stable(sector_o) && $stable(outside_o), "stalled result changed")

  // Outside cells carry no segment
  `PRC_ASSERT_NOW(a_outside_zero, clk_i, rst_ni, out_valid_o && outside_o, segment_id_o == '0 && ring_index_o == '0 && sector_o == '0, "outside cell has a segment")

  // Segment number follows ring and sector
  `PRC_ASSERT_NOW(a_seg_code, clk_i, rst_ni, out_valid_o && segment_id_o != '0, !outside_o && segment_id_o == ({ring_index_o, sector_o} + SEG_W'(1)), "segment id mismatch")

  // Segment zero means centre or outside: ring and sector are zero
  `PRC_ASSERT_NOW(a_seg_zero, clk_i, rst_ni, out_valid_o && segment_id_o == '0, ring_index_o == '0 && sector_o == '0, "segment zero with ring or sector")

endmodule

bind polar_ring_sector_classifier prc_checker u_prc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .segment_id_o (segment_id_o),
  .ring_index_o (ring_index_o),
  .sector_o     (sector_o),
  .outside_o    (outside_o)
);
